// ----- hw/rtl/lbmh_pkg.sv -----
// shared types and constants for the lux block mean hysteresis filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lbmh_pkg;

  localparam int unsigned SAMPLE_BITS       = 16;
  localparam int unsigned HISTORY_DEPTH_DEF = 8;
  localparam int unsigned MAX_BLOCK         = 64;
  localparam int unsigned CNT_W             = $clog2(MAX_BLOCK + 1);
  localparam int unsigned CFG_W             = 6;
  localparam logic [CFG_W-1:0] BLOCK_LEN_RESET = CFG_W'(7);

  // new level = (2*old + 8*mean) / 10
  localparam int unsigned LEVEL_OLD_SHIFT = 1;
  localparam int unsigned LEVEL_NEW_SHIFT = 3;

  // x / 10 as (x * ceil(2^23 / 10)) >> 23, exact for x below 2^22
  localparam int unsigned LEVEL_RECIP_W     = 20;
  localparam logic [LEVEL_RECIP_W-1:0] LEVEL_RECIP = LEVEL_RECIP_W'(838861);
  localparam int unsigned LEVEL_RECIP_SHIFT = 23;

  localparam int unsigned SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int unsigned LVL_NUM_W = SAMPLE_BITS + 4;
  localparam int unsigned PROD_W    = LVL_NUM_W + LEVEL_RECIP_W;
  localparam int unsigned DIV_W     = SUM_W;
  localparam int unsigned DIVR_W    = CNT_W;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified sample on its way from front to back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CNT_W-1:0]       count;   // samples in block including this one
    logic                   first;   // opens a block
    logic                   last;    // closes a block
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_PUSH,
    B_MEAN,
    B_LVL,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/lux_block_mean_hysteresis_filter_unit.sv -----
// top level of the lux block mean hysteresis filter
// depends on lbmh_pkg, lbmh_front, lbmh_queue, lbmh_div, lbmh_back
//
//   channel   direction  handshake                  payload
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_data_i (block length minus one)
//   sample    in         in_valid_i / in_stall_o    lux_sample_i
//   level     out        out_valid_o / out_stall_i  level_valid_o, stable_level_o
//
// a mid-block sample goes through pop, ring write and result load in the back end
// a block's first sample adds a min/max scan of the ring once the ring is full
// a block's last sample adds the mean on the bit-serial divider,
// and a level step when the level moves (divide by ten by reciprocal multiply)
// reset is asynchronous active low and needs no clearing pass; cfg is always ready
// the two-entry queue takes samples while the back end works or the output stalls, until it is full
`timescale 1ns / 1ps
`default_nettype none

module lux_block_mean_hysteresis_filter_unit #(
  parameter int unsigned HISTORY_DEPTH = lbmh_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [lbmh_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             in_valid_i,
  input  wire logic [lbmh_pkg::SAMPLE_BITS-1:0] lux_sample_i,
  output logic                                  in_stall_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  level_valid_o,
  output logic [lbmh_pkg::SAMPLE_BITS-1:0]      stable_level_o
);
  import lbmh_pkg::*;

  logic              push_valid, push_stall;
  item_t             push_item;
  logic              pop_valid, pop_stall;
  item_t             pop_item;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dividend, div_quotient;
  logic [DIVR_W-1:0] div_divisor;

  lbmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .in_valid_i   (in_valid_i),
    .lux_sample_i (lux_sample_i),
    .in_stall_o   (in_stall_o),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_stall_i (push_stall)
  );

  lbmh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_stall_o (push_stall),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_stall_i  (pop_stall)
  );

  lbmh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  lbmh_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_item_i     (pop_item),
    .pop_stall_o    (pop_stall),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_valid_o  (level_valid_o),
    .stable_level_o (stable_level_o),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lbmh_front.sv -----
// front end: config register, sample intake and block position tagging
// depends on lbmh_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbmh_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [lbmh_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                              cfg_ready_o,
  input  wire logic                         in_valid_i,
  input  wire logic [lbmh_pkg::SAMPLE_BITS-1:0] lux_sample_i,
  output logic                              in_stall_o,
  output logic                              push_valid_o,
  output lbmh_pkg::item_t                   push_item_o,
  input  wire logic                         push_stall_i
);
  import lbmh_pkg::*;

  logic [CFG_W-1:0] blen_q, blen_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] n;
  logic             last;
  logic             accept;

  assign cfg_ready_o  = 1'b1;
  assign push_valid_o = in_valid_i;
  assign in_stall_o   = push_stall_i;
  assign accept       = in_valid_i && !push_stall_i;

  // block closes once the count passes the register or hits the cap
  assign n    = count_q + CNT_W'(1);
  assign last = (n > CNT_W'(blen_q)) || (n >= CNT_W'(MAX_BLOCK));

  always_comb begin
    push_item_o.sample = lux_sample_i;
    push_item_o.count  = n;
    push_item_o.first  = (count_q == '0);
    push_item_o.last   = last;
  end

  always_comb begin
    blen_d  = cfg_valid_i ? cfg_data_i : blen_q;
    count_d = count_q;
    if (accept) begin
      count_d = last ? '0 : n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q  <= BLOCK_LEN_RESET;
      count_q <= '0;
    end else begin
      blen_q  <= blen_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lbmh_queue.sv -----
// short request queue between the front end and the back end
// depends on lbmh_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbmh_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  input  wire lbmh_pkg::item_t  push_item_i,
  output logic                  push_stall_o,
  output logic                  pop_valid_o,
  output lbmh_pkg::item_t       pop_item_o,
  input  wire logic             pop_stall_i
);
  import lbmh_pkg::*;

  localparam int unsigned QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t           mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QC_W-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_stall_o = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QP_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QP_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lbmh_div.sv -----
// restoring divider, one quotient bit per cycle, used for the block mean
// depends on lbmh_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbmh_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lbmh_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [lbmh_pkg::DIVR_W-1:0] divisor_i,
  output logic                             done_o,
  output logic [lbmh_pkg::DIV_W-1:0]       quotient_o
);
  import lbmh_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [DIVR_W-1:0] dvs_q, dvs_d;
  logic [DIVR_W:0]   rem_sh, rem_sub;
  logic              ge;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = (rem_sh >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      step_d = step_q - STEP_W'(1);
      rem_d  = ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      quo_d  = {quo_q[DIV_W-2:0], ge};
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lbmh_back.sv -----
// back end: history ring, band scan, block sum, level update and result register
// depends on lbmh_pkg; drives the lbmh_div unit for the block mean
`timescale 1ns / 1ps
`default_nettype none

module lbmh_back #(
  parameter int unsigned HISTORY_DEPTH = lbmh_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             pop_valid_i,
  input  wire lbmh_pkg::item_t                  pop_item_i,
  output logic                                  pop_stall_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  level_valid_o,
  output logic [lbmh_pkg::SAMPLE_BITS-1:0]      stable_level_o,
  output logic                                  div_start_o,
  output logic [lbmh_pkg::DIV_W-1:0]            div_dividend_o,
  output logic [lbmh_pkg::DIVR_W-1:0]           div_divisor_o,
  input  wire logic                             div_done_i,
  input  wire logic [lbmh_pkg::DIV_W-1:0]       div_quotient_i
);
  import lbmh_pkg::*;

  localparam int unsigned HI_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned HF_W = $clog2(HISTORY_DEPTH + 1);

  back_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] ring_q [HISTORY_DEPTH];
  logic                   ring_we;
  logic [HI_W-1:0]        head_q, head_d;
  logic [HF_W-1:0]        fill_q, fill_d;
  logic [HI_W-1:0]        idx_q, idx_d;
  logic [SAMPLE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                   band_ok_q, band_ok_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] held_q, held_d;
  logic                   held_valid_q, held_valid_d;
  item_t                  cur_q, cur_d;
  logic                   res_lv_q, res_lv_d;
  logic [SAMPLE_BITS-1:0] res_level_q, res_level_d;
  logic                   out_valid_q, out_valid_d;
  logic                   lv_q, lv_d;
  logic [SAMPLE_BITS-1:0] level_q, level_d;

  logic                   fill_full;
  logic [SAMPLE_BITS-1:0] scan_v;
  logic [SAMPLE_BITS-1:0] mean;
  logic                   in_band;
  logic                   out_free;
  logic [SUM_W-1:0]       sum_new;
  logic [LVL_NUM_W-1:0]   lvl_num;
  logic [PROD_W-1:0]      lvl_prod;
  logic [SAMPLE_BITS-1:0] lvl_new;

  assign fill_full = (fill_q == HF_W'(HISTORY_DEPTH));
  assign scan_v    = ring_q[idx_q];
  assign mean      = div_quotient_i[SAMPLE_BITS-1:0];
  assign in_band   = band_ok_q && (mean >= lo_q) && (mean <= hi_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign sum_new   = sum_q + SUM_W'(cur_q.sample);

  // blended level, divide by ten through the reciprocal
  assign lvl_num  = (LVL_NUM_W'(held_q) << LEVEL_OLD_SHIFT)
                  + (LVL_NUM_W'(mean) << LEVEL_NEW_SHIFT);
  assign lvl_prod = PROD_W'(lvl_num) * PROD_W'(LEVEL_RECIP);
  assign lvl_new  = lvl_prod[LEVEL_RECIP_SHIFT +: SAMPLE_BITS];

  assign pop_stall_o    = (state_q != B_IDLE);
  assign out_valid_o    = out_valid_q;
  assign level_valid_o  = lv_q;
  assign stable_level_o = level_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = (pop_item_i.first && fill_full) ? B_SCAN : B_PUSH;
        end
      end
      B_SCAN: begin
        if (idx_q == HI_W'(HISTORY_DEPTH - 1)) begin
          state_d = B_PUSH;
        end
      end
      B_PUSH: begin
        state_d = cur_q.last ? B_MEAN : B_OUT;
      end
      B_MEAN: begin
        if (div_done_i) begin
          state_d = (!held_valid_q || in_band) ? B_OUT : B_LVL;
        end
      end
      B_LVL: begin
        state_d = B_OUT;
      end
      B_OUT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_d          = cur_q;
    idx_d          = idx_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    band_ok_d      = band_ok_q;
    head_d         = head_q;
    fill_d         = fill_q;
    sum_d          = sum_q;
    held_d         = held_q;
    held_valid_d   = held_valid_q;
    res_lv_d       = res_lv_q;
    res_level_d    = res_level_q;
    ring_we        = 1'b0;
    div_start_o    = 1'b0;
    div_dividend_o = DIV_W'(sum_new);
    div_divisor_o  = DIVR_W'(cur_q.count);
    out_valid_d    = out_valid_q && out_stall_i;
    lv_d           = lv_q;
    level_d        = level_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          cur_d = pop_item_i;
          // band is latched before the block's first sample enters the ring
          if (pop_item_i.first) begin
            band_ok_d = fill_full;
            idx_d     = '0;
            lo_d      = '1;
            hi_d      = '0;
          end
        end
      end
      B_SCAN: begin
        if (scan_v < lo_q) begin
          lo_d = scan_v;
        end
        if (scan_v > hi_q) begin
          hi_d = scan_v;
        end
        idx_d = idx_q + HI_W'(1);
      end
      B_PUSH: begin
        ring_we = 1'b1;
        head_d  = (head_q == HI_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + HI_W'(1);
        if (!fill_full) begin
          fill_d = fill_q + HF_W'(1);
        end
        sum_d = sum_new;
        if (cur_q.last) begin
          div_start_o = 1'b1;
        end else begin
          res_lv_d    = 1'b0;
          res_level_d = '0;
        end
      end
      B_MEAN: begin
        if (div_done_i) begin
          sum_d    = '0;
          res_lv_d = 1'b1;
          if (!held_valid_q) begin
            held_d       = mean;
            held_valid_d = 1'b1;
            res_level_d  = mean;
          end else if (in_band) begin
            res_level_d = held_q;
          end
        end
      end
      B_LVL: begin
        held_d      = lvl_new;
        res_level_d = lvl_new;
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          lv_d        = res_lv_q;
          level_d     = res_level_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      idx_q        <= '0;
      band_ok_q    <= 1'b0;
      sum_q        <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      idx_q        <= idx_d;
      band_ok_q    <= band_ok_d;
      sum_q        <= sum_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    res_lv_q    <= res_lv_d;
    res_level_q <= res_level_d;
    lv_q        <= lv_d;
    level_q     <= level_d;
    if (ring_we) begin
      ring_q[head_q] <= cur_q.sample;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> (state_q == B_MEAN))
    else $error("divider finished outside the mean state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= HF_W'(HISTORY_DEPTH))
    else $error("history fill count overran the ring");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !lv_q) |-> (level_q == '0))
    else $error("level not zero on a collecting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SCAN) |-> band_ok_q)
    else $error("band scan started on a partial history");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == B_OUT))
    else $error("result loaded outside the output state");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// testbench for lux_block_mean_hysteresis_filter_unit: block mean, min/max band hold, level blend
// depends on lbmh_pkg and the filter rtl; self-checking against an in-bench level predictor
`timescale 1ns / 1ps

module tb;
  import lbmh_pkg::*;

  localparam int unsigned HIST      = HISTORY_DEPTH_DEF;
  localparam int unsigned LIMIT     = 1_000_000;
  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic                   lv;
    logic [SAMPLE_BITS-1:0] level;
  } level_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   cfg_ready_o;
  logic                   in_valid_i = 1'b0;
  logic [SAMPLE_BITS-1:0] lux_sample_i = '0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   level_valid_o;
  logic [SAMPLE_BITS-1:0] stable_level_o;

  lux_block_mean_hysteresis_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_ready_o   (cfg_ready_o),
    .in_valid_i    (in_valid_i),
    .lux_sample_i  (lux_sample_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .level_valid_o (level_valid_o),
    .stable_level_o(stable_level_o)
  );

  always #5 clk_i = ~clk_i;

  logic [SAMPLE_BITS-1:0] sample_q[$];
  level_t                 level_q[$];
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_idle_pct = 0;
  bit                     send_hold = 1'b0;
  bit                     in_taken = 1'b0;
  bit                     cfg_taken = 1'b0;
  int unsigned            err_cnt = 0;
  int unsigned            cycle_cnt = 0;
  int                     base_lux = 20000;

  // predictor state
  logic [CFG_W-1:0]       blk_len_m1 = BLOCK_LEN_RESET;
  int unsigned            acc_sum = 0;
  int unsigned            acc_cnt = 0;
  logic [SAMPLE_BITS-1:0] ring[HIST];
  int unsigned            ring_fill = 0;
  int unsigned            ring_head = 0;
  int unsigned            level_hold = 0;
  bit                     level_set = 1'b0;
  int unsigned            band_lo = 0;
  int unsigned            band_hi = 0;
  bit                     band_full = 1'b0;

  task automatic predict_level(input logic [SAMPLE_BITS-1:0] s);
    int unsigned mean;
    level_t      res;
    // band is taken from the ring before the block's first sample goes in
    if (acc_cnt == 0) begin
      band_full = (ring_fill >= HIST);
      band_lo = 0;
      band_hi = 0;
      if (band_full) begin
        band_lo = (1 << SAMPLE_BITS) - 1;
        for (int i = 0; i < HIST; i++) begin
          if (ring[i] < band_lo) band_lo = ring[i];
          if (ring[i] > band_hi) band_hi = ring[i];
        end
      end
    end
    ring[ring_head] = s;
    ring_head = (ring_head + 1) % HIST;
    if (ring_fill < HIST) ring_fill++;
    acc_sum += s;
    acc_cnt++;
    if (acc_cnt <= blk_len_m1 && acc_cnt < MAX_BLOCK) begin
      res = '{lv: 1'b0, level: '0};
    end else begin
      mean = acc_sum / acc_cnt;
      acc_sum = 0;
      acc_cnt = 0;
      if (!level_set) begin
        level_hold = mean;
        level_set = 1'b1;
      end else if (!(band_full && mean >= band_lo && mean <= band_hi)) begin
        level_hold = ((2 * level_hold + 8 * mean) / 10) & ((1 << SAMPLE_BITS) - 1);
      end
      res = '{lv: 1'b1, level: level_hold[SAMPLE_BITS-1:0]};
    end
    level_q.push_back(res);
  endtask

  // sample request driver and output stall
  always @(negedge clk_i) begin : drive_proc
    logic                   nxt_valid;
    logic [SAMPLE_BITS-1:0] nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = lux_sample_i;
    if (!in_valid_i || in_taken) begin
      nxt_valid = 1'b0;
      if (rst_ni && !send_hold && sample_q.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data  = sample_q.pop_front();
      end
    end
    in_valid_i   <= nxt_valid;
    lux_sample_i <= nxt_data;
    out_stall_i  <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk_i) begin : mon_proc
    level_t exp_res;
    in_taken  = rst_ni && in_valid_i && !in_stall_o;
    cfg_taken = rst_ni && cfg_valid_i && cfg_ready_o;
    if (cfg_taken) blk_len_m1 = cfg_data_i;
    if (in_taken) predict_level(lux_sample_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (level_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("unexpected level result: valid=%0b level=%0d",
                   level_valid_o, stable_level_o);
      end else begin
        exp_res = level_q.pop_front();
        if (level_valid_o !== exp_res.lv || stable_level_o !== exp_res.level) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("level mismatch: expected valid=%0b level=%0d, got valid=%0b level=%0d",
                     exp_res.lv, exp_res.level, level_valid_o, stable_level_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_block_len(input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i = 1'b0;
  endtask

  // settle past a rising edge so queue and valid are both current
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while ((!send_hold && sample_q.size() != 0) || in_valid_i || level_q.size() != 0);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] gen_sample();
    int unsigned r;
    int          sp;
    int          v;
    r = $urandom_range(99);
    if (r < 8) return SAMPLE_BITS'($urandom);
    if (r < 12) return ($urandom_range(1) != 0) ? '1 : '0;
    if (r < 17) begin
      base_lux = $urandom_range((1 << SAMPLE_BITS) - 1);
      return base_lux[SAMPLE_BITS-1:0];
    end
    // steady light with small jitter keeps block means inside the band
    sp = $urandom_range(64);
    v  = base_lux + $urandom_range(2 * sp) - sp;
    if (v < 0) v = 0;
    if (v > (1 << SAMPLE_BITS) - 1) v = (1 << SAMPLE_BITS) - 1;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return CFG_W'(1);
      3: return CFG_W'(7);
      4: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic run_phase(input int unsigned n_items, input int unsigned s_pct,
                           input int unsigned r_pct, input bit with_hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int c = 0; c < 4; c++) begin
      write_block_len(pick_len());
      for (int i = 0; i < n_items / 4; i++) sample_q.push_back(gen_sample());
      if (with_hold && c == 1) begin
        while (sample_q.size() > n_items / 8) @(posedge clk_i);
        // sender holds off until every result is back
        send_hold = 1'b1;
        wait_idle();
        repeat (20) @(posedge clk_i);
        send_hold = 1'b0;
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset length: one block of 8 with the field extremes, first mean sets the level
    sample_q.push_back('0);
    sample_q.push_back('1);
    sample_q.push_back(16'h5555);
    sample_q.push_back(16'hAAAA);
    sample_q.push_back(16'h0001);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back('1);
    wait_idle();

    // single-sample blocks: wide band holds, then a flat band that the means leave
    write_block_len('0);
    sample_q.push_back(16'h5555);
    repeat (8) sample_q.push_back(16'd1000);
    sample_q.push_back(16'd2000);
    sample_q.push_back('0);
    wait_idle();

    // longest block open, then shortened mid-block so the next sample closes it
    write_block_len('1);
    sample_q.push_back(16'd300);
    sample_q.push_back(16'd400);
    sample_q.push_back(16'd500);
    wait_idle();
    write_block_len(CFG_W'(2));
    sample_q.push_back(16'd600);
    wait_idle();

    run_phase(320, 22, 84, 1'b1);
    run_phase(320, 84, 22, 1'b0);
    run_phase(320, 0, 0, 1'b0);

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (level_q.size() != 0)
      $display("expected level results left over: %0d", level_q.size());
    if (err_cnt == 0 && level_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
